// ===== rtl/core/r2fft_pkg.sv =====
// Package for the radix-2 FFT: widths, sequencer state type, twiddle ROM.
// No dependencies.
package r2fft_pkg;
	localparam int SAMPLE_W = 16;
	localparam int BIN_W    = 22;
	localparam int FRAC_W   = 15;
	localparam int ROM_LOG2 = 6;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CALC,
		ST_DRAIN
	} fft_state_t;

	// Sample pushed from the front end to the core
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
	} samp_t;

	// Quarter-wave cosine, Q1.15, 1.0 held as 32767
	function automatic logic signed [17:0] qcos(input logic [4:0] i);
		unique case (i)
			5'd0:  qcos = 18'sd32767;
			5'd1:  qcos = 18'sd32610;
			5'd2:  qcos = 18'sd32138;
			5'd3:  qcos = 18'sd31357;
			5'd4:  qcos = 18'sd30274;
			5'd5:  qcos = 18'sd28899;
			5'd6:  qcos = 18'sd27246;
			5'd7:  qcos = 18'sd25330;
			5'd8:  qcos = 18'sd23170;
			5'd9:  qcos = 18'sd20788;
			5'd10: qcos = 18'sd18205;
			5'd11: qcos = 18'sd15447;
			5'd12: qcos = 18'sd12540;
			5'd13: qcos = 18'sd9512;
			5'd14: qcos = 18'sd6393;
			5'd15: qcos = 18'sd3212;
			default: qcos = 18'sd0;
		endcase
	endfunction

	// Twiddle cos and sin for angle index t out of 64
	function automatic logic signed [35:0] twid(input logic [4:0] t);
		logic signed [17:0] c;
		logic signed [17:0] s;
		if (t <= 5'd16) begin
			c = qcos(t);
			s = qcos(5'd16 - t);
		end else begin
			c = -qcos(5'd0 - t);
			s = qcos(t - 5'd16);
		end
		twid = {c, s};
	endfunction
endpackage

// ===== rtl/core/r2fft_front.sv =====
// Front end: input skid queue (two entries) ahead of the transform core.
// Depends on r2fft_pkg.
module r2fft_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    flush,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  r2fft_pkg::samp_t        in_data,
	output logic                    q_valid,
	input  logic                    q_ready,
	output r2fft_pkg::samp_t        q_data
);
	import r2fft_pkg::*;

	samp_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else if (flush) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((in_valid && in_ready) ? 1 : 0)
			      - 2'((q_valid && q_ready) ? 1 : 0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !flush && !q_ready) |=> !in_ready)
		else $error("full queue accepted");
	assert property (@(posedge clk) disable iff (!arst_n) flush |=> cnt_q == 2'd0)
		else $error("flush left entries");
endmodule

// ===== rtl/core/r2fft_core.sv =====
// Back end: sample store, butterfly sequencer, and bin drain with output
// register. Depends on r2fft_pkg.
module r2fft_core #(
	parameter int MAX_POINTS = 64,
	parameter int AW         = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_lg,
	input  logic                          s_valid,
	output logic                          s_ready,
	input  r2fft_pkg::samp_t              s_data,
	output logic                          o_valid,
	input  logic                          o_ready,
	output logic signed [r2fft_pkg::BIN_W-1:0] o_re,
	output logic signed [r2fft_pkg::BIN_W-1:0] o_im,
	output logic [5:0]                    o_idx,
	output logic                          o_last
);
	import r2fft_pkg::*;

	localparam logic [2:0] MAXLG = 3'(AW);
	localparam int BMAX = (1 << (BIN_W - 1)) - 1;

	logic signed [BIN_W-1:0] re_mem [MAX_POINTS];
	logic signed [BIN_W-1:0] im_mem [MAX_POINTS];

	fft_state_t state_q, state_d;
	logic [2:0]  lg_q;
	logic [AW:0] cnt_q;        // load count / drain address
	logic [2:0]  st_q;         // butterfly stage
	logic [AW-1:0] bf_q;       // butterfly number in stage
	logic [1:0]  ph_q;         // phase within butterfly
	logic [AW:0] npts;

	// effective size
	logic [2:0] lg_eff;
	always_comb begin
		lg_eff = lg_q;
		if (lg_eff == 3'd0) lg_eff = 3'd1;
		if (lg_eff > MAXLG) lg_eff = MAXLG;
	end
	assign npts = (AW+1)'(1) << lg_eff;

	// bit reversed load address
	logic [AW-1:0] rev_addr;
	always_comb begin
		rev_addr = '0;
		for (int i = 0; i < AW; i++)
			if (i < int'(lg_eff)) rev_addr[i] = cnt_q[int'(lg_eff) - 1 - i];
	end

	// butterfly addresses
	logic [AW-1:0] half, k_idx, top_a, bot_a, lo_mask;
	logic [4:0]    tw_idx;
	always_comb begin
		half    = AW'(1) << st_q;
		lo_mask = half - AW'(1);
		k_idx   = bf_q & lo_mask;
		top_a   = ((bf_q & ~lo_mask) << 1) | k_idx;
		bot_a   = top_a | half;
		tw_idx  = 5'((32'(k_idx) << (5 - int'(st_q))));
	end

	// memory read registers
	logic signed [BIN_W-1:0] rd_re_q, rd_im_q, a_re_q, a_im_q;
	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = bot_a;
		if (state_q == ST_CALC && ph_q == 2'd1) rd_addr = top_a;
		if (state_q == ST_DRAIN) rd_addr = cnt_q[AW-1:0];
	end

	// product stage
	logic signed [17:0] tw_c, tw_s;
	logic signed [40:0] pr_s1, pi_s1;
	assign {tw_c, tw_s} = twid(tw_idx);

	logic signed [BIN_W+1:0] pr_w, pi_w;
	logic signed [40:0] pr_f, pi_f;
	assign pr_f = (pr_s1 + 41'sd16384) >>> FRAC_W;
	assign pi_f = (pi_s1 + 41'sd16384) >>> FRAC_W;
	assign pr_w = (BIN_W+2)'(pr_f);
	assign pi_w = (BIN_W+2)'(pi_f);

	function automatic logic signed [BIN_W-1:0] sat(input logic signed [BIN_W+1:0] x);
		if (x > (BIN_W+2)'(BMAX)) sat = BIN_W'(BMAX);
		else if (x < -(BIN_W+2)'(BMAX) - 1) sat = BIN_W'(-BMAX - 1);
		else sat = BIN_W'(x);
	endfunction

	logic out_free;
	logic drain_rd_q;
	logic [AW:0] drain_idx_q;
	assign out_free = !o_valid || o_ready;
	assign s_ready  = (state_q == ST_LOAD) && !cfg_we;

	// store access: load writes, butterfly phases, drain reads
	// phase 2 writes the top output from the top word read in phase 1
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && s_valid && s_ready) begin
			re_mem[rev_addr] <= BIN_W'(s_data.re);
			im_mem[rev_addr] <= BIN_W'(s_data.im);
		end else if (state_q == ST_CALC && ph_q == 2'd2) begin
			re_mem[top_a] <= sat((BIN_W+2)'(rd_re_q) + pr_w);
			im_mem[top_a] <= sat((BIN_W+2)'(rd_im_q) + pi_w);
		end else if (state_q == ST_CALC && ph_q == 2'd3) begin
			re_mem[bot_a] <= sat((BIN_W+2)'(a_re_q) - pr_w);
			im_mem[bot_a] <= sat((BIN_W+2)'(a_im_q) - pi_w);
		end
		rd_re_q <= re_mem[rd_addr];
		rd_im_q <= im_mem[rd_addr];
		if (ph_q == 2'd1) begin
			pr_s1 <= 41'(rd_re_q * tw_c) + 41'(rd_im_q * tw_s);
			pi_s1 <= 41'(rd_im_q * tw_c) - 41'(rd_re_q * tw_s);
		end
		if (ph_q == 2'd2 && state_q == ST_CALC) begin
			a_re_q <= rd_re_q;
			a_im_q <= rd_im_q;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			lg_q        <= 3'd6;
			cnt_q       <= '0;
			st_q        <= '0;
			bf_q        <= '0;
			ph_q        <= '0;
			o_valid     <= 1'b0;
			o_re        <= '0;
			o_im        <= '0;
			o_idx       <= '0;
			o_last      <= 1'b0;
			drain_rd_q  <= 1'b0;
			drain_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				lg_q  <= cfg_lg;
				cnt_q <= '0;
			end else begin
				unique case (state_q)
					ST_LOAD: begin
						if (s_valid) cnt_q <= (cnt_q + 1'b1 == npts) ? '0 : cnt_q + 1'b1;
						st_q <= '0; bf_q <= '0; ph_q <= '0;
					end
					ST_CALC: begin
						ph_q <= ph_q + 2'd1;
						if (ph_q == 2'd3) begin
							if (32'(bf_q) + 1 == (32'(npts) >> 1)) begin
								bf_q <= '0;
								st_q <= st_q + 3'd1;
							end else bf_q <= bf_q + 1'b1;
						end
					end
					ST_DRAIN: begin
						if (state_d == ST_LOAD) cnt_q <= '0;
						else if (out_free && !drain_rd_q && cnt_q != npts) begin
							drain_rd_q  <= 1'b1;
							drain_idx_q <= cnt_q;
							cnt_q       <= cnt_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (drain_rd_q) begin
				drain_rd_q <= 1'b0;
				o_valid    <= 1'b1;
				o_re       <= rd_re_q;
				o_im       <= rd_im_q;
				o_idx      <= 6'(drain_idx_q);
				o_last     <= (drain_idx_q == npts - 1'b1);
			end else if (o_valid && o_ready) o_valid <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (s_valid && s_ready && cnt_q + 1'b1 == npts) state_d = ST_CALC;
			ST_CALC:  if (ph_q == 2'd3 && 32'(bf_q) + 1 == (32'(npts) >> 1)
			              && st_q + 3'd1 == lg_eff) state_d = ST_DRAIN;
			ST_DRAIN: if (cnt_q == npts && !drain_rd_q && o_valid && o_ready && o_last)
				state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid && !o_ready) |=> (o_valid && $stable(o_idx)))
		else $error("output dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> !s_ready)
		else $error("sample taken during transform");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (st_q < lg_eff))
		else $error("stage overrun");
endmodule

// ===== rtl/core/radix2_fft.sv =====
// Top level of the radix-2 decimation-in-time FFT.
// Instantiates r2fft_front and r2fft_core; depends on r2fft_pkg.
//
// Usage: samples enter on sample_valid/sample_ready, one complex Q1.15
// value per transaction. After N = 2^points_log2 samples the core runs
// log2(N)*N/2 butterflies through one complex multiplier (four real products)
// and one store with a read and a write port, then emits N bins in index order
// on bin_valid/bin_ready, last_bin set on the final one.
// Per frame the core loads N samples, runs the transform, then drains the bins;
// it reads the next bin only once the previous one is in the output register.
// Input is blocked during transform and drain; a two-entry queue absorbs
// input meanwhile.
// A stalled bin_ready holds the current bin and pauses the drain.
// Reset empties the queue, clears the load count and sets points_log2 to 6.
// A write to cfg_we drops any partial frame.
module radix2_fft #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_wdata,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic signed [15:0] sample_real,
	input  logic signed [15:0] sample_imag,
	output logic               bin_valid,
	input  logic               bin_ready,
	output logic signed [21:0] bin_real,
	output logic signed [21:0] bin_imag,
	output logic [5:0]         bin_index,
	output logic               last_bin
);
	import r2fft_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	samp_t in_d, q_d;
	logic  q_valid, q_ready;

	assign in_d.re = sample_real;
	assign in_d.im = sample_imag;

	r2fft_front u_front (
		.clk(clk), .arst_n(arst_n), .flush(cfg_we),
		.in_valid(sample_valid), .in_ready(sample_ready), .in_data(in_d),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_d)
	);

	r2fft_core #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_core (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_lg(cfg_wdata),
		.s_valid(q_valid), .s_ready(q_ready), .s_data(q_d),
		.o_valid(bin_valid), .o_ready(bin_ready),
		.o_re(bin_real), .o_im(bin_imag), .o_idx(bin_index), .o_last(last_bin)
	);
endmodule
